FILE: hw/rtl/tvpz_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tvpz_pkg
// Types, codes and helpers shared by the viewport pan/zoom block.
// ----------------------------------------------------------------------------
package tvpz_pkg;

   localparam int TILE_PIXELS_DEF = 256;
   localparam int MAX_LEVEL_DEF   = 22;

   localparam logic [4:0]  RESET_LEVEL = 5'd2;
   localparam logic [12:0] RESET_SIZE  = 13'd256;
   localparam logic [4:0]  ZOOM_FROM_FLOOR = 5'd2;
   localparam logic [4:0]  ZOOM_OUT_FLOOR  = 5'd3;

   typedef enum logic [3:0] {
      KIND_PAN        = 4'd0,
      KIND_ZOOM_AT    = 4'd1,
      KIND_ZOOM_FROM  = 4'd2,
      KIND_ZOOM_IN    = 4'd3,
      KIND_ZOOM_OUT   = 4'd4,
      KIND_RESIZE     = 4'd5,
      KIND_CLAMP_WRAP = 4'd6,
      KIND_QUERY      = 4'd7,
      KIND_INIT       = 4'd8
   } tvpz_kind_type;

   typedef struct packed {
      logic        [3:0]  kind;
      logic signed [31:0] arg_x;
      logic signed [31:0] arg_y;
      logic        [12:0] new_width;
      logic        [12:0] new_height;
      logic        [4:0]  new_zoom;
   } tvpz_req_type;

   typedef struct packed {
      logic signed [31:0] offset_x;
      logic signed [31:0] offset_y;
      logic        [4:0]  zoom_level;
      logic signed [23:0] first_tile_x;
      logic signed [23:0] first_tile_y;
      logic signed [23:0] end_tile_x;
      logic signed [23:0] end_tile_y;
   } tvpz_rsp_type;

   typedef struct packed {
      logic [31:0] left;
      logic [31:0] top;
      logic [4:0]  level;
      logic [12:0] width;
      logic [12:0] height;
   } tvpz_view_type;

   // halve, truncating toward zero
   function automatic logic [31:0] half_trunc(input logic [31:0] d);
      logic [31:0] s;
      s = d + {31'd0, d[31]};
      return {s[31], s[31:1]};
   endfunction

   // (offset - size/2) / 2, truncating toward zero
   function automatic logic [31:0] half_back(input logic [31:0] off,
                                             input logic [12:0] size);
      return half_trunc(off - {20'd0, size[12:1]});
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/tile_viewport_pan_zoom.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tile_viewport_pan_zoom
// Viewport offset, zoom level and size over a tile pyramid, with tile range.
// ----------------------------------------------------------------------------
//   channel | direction | handshake                  | payload
//   req     | in        | req_valid / req_ready      | tvpz_req_type
//   rsp     | out       | rsp_valid / rsp_ready      | tvpz_rsp_type
//
// One request per cycle while the response register is empty or being drained;
// its response appears in the cycle after acceptance. The view state and the
// response register update at the same edge, so the next request already sees the new state.
// req_ready is high while the response register is empty or being drained.
// Reset: offsets 0, level 2, view 256 x 256, no response pending.
// ----------------------------------------------------------------------------
module tile_viewport_pan_zoom #(
   parameter int TILE_PIXELS = tvpz_pkg::TILE_PIXELS_DEF,
   parameter int MAX_LEVEL   = tvpz_pkg::MAX_LEVEL_DEF
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  tvpz_pkg::tvpz_req_type  req_data,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output tvpz_pkg::tvpz_rsp_type  rsp_data
);
   import tvpz_pkg::*;

   localparam int TILE_SHIFT = $clog2(TILE_PIXELS);
   localparam int LVL_TOP    = (MAX_LEVEL > 2) ? MAX_LEVEL : 2;

   tvpz_view_type view_ff;
   tvpz_view_type view_in;
   tvpz_view_type view_next;
   tvpz_rsp_type  rsp_ff;
   tvpz_rsp_type  rsp_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          req_fire;

   function automatic logic [23:0] tile_div(input logic [31:0] v);
      logic [31:0]        s;
      logic signed [31:0] q;
      s = v + (v[31] ? 32'(TILE_PIXELS - 1) : 32'd0);
      q = $signed(s) >>> TILE_SHIFT;
      return q[23:0];
   endfunction

   tvpz_step #(
      .TILE_PIXELS (TILE_PIXELS),
      .MAX_LEVEL   (MAX_LEVEL)
   ) u_step (
      .view      (view_ff),
      .req       (req_data),
      .view_next (view_next)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      view_in      = req_fire ? view_next : view_ff;
      rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_ready);

      rsp_in              = rsp_ff;
      rsp_in.offset_x     = view_next.left;
      rsp_in.offset_y     = view_next.top;
      rsp_in.zoom_level   = view_next.level;
      rsp_in.first_tile_x = tile_div(view_next.left);
      rsp_in.first_tile_y = tile_div(view_next.top);
      rsp_in.end_tile_x   = tile_div(view_next.left + {19'd0, view_next.width}) + 24'd1;
      rsp_in.end_tile_y   = tile_div(view_next.top + {19'd0, view_next.height}) + 24'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         view_ff.left   <= 32'd0;
         view_ff.top    <= 32'd0;
         view_ff.level  <= RESET_LEVEL;
         view_ff.width  <= RESET_SIZE;
         view_ff.height <= RESET_SIZE;
         rsp_valid_ff   <= 1'b0;
      end else begin
         view_ff      <= view_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   a_fire_gives_rsp : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid)
      else $error("accepted request produced no response");

   a_idle_holds_view : assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(view_ff))
      else $error("view state changed without a request");

   a_level_bound : assert property (@(posedge clock) disable iff (reset)
      view_ff.level <= 5'(LVL_TOP))
      else $error("zoom level out of range");

   a_rsp_matches_view : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.offset_x == view_ff.left &&
                     rsp_data.offset_y == view_ff.top &&
                     rsp_data.zoom_level == view_ff.level))
      else $error("pending response disagrees with view state");

endmodule
`default_nettype wire

FILE: hw/rtl/tvpz_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tvpz_step
// Next viewport state for one request: pan, zoom, resize, clamp/wrap, init; a query leaves it as is.
// ----------------------------------------------------------------------------
module tvpz_step #(
   parameter int TILE_PIXELS = tvpz_pkg::TILE_PIXELS_DEF,
   parameter int MAX_LEVEL   = tvpz_pkg::MAX_LEVEL_DEF
) (
   input  tvpz_pkg::tvpz_view_type view,
   input  tvpz_pkg::tvpz_req_type  req,
   output tvpz_pkg::tvpz_view_type view_next
);
   import tvpz_pkg::*;

   localparam int TILE_SHIFT = $clog2(TILE_PIXELS);
   localparam int LVL_TOP    = (MAX_LEVEL > 2) ? MAX_LEVEL : 2;
   localparam int CW = (TILE_SHIFT + LVL_TOP + 2 > 33) ? TILE_SHIFT + LVL_TOP + 2 : 33;
   localparam logic [4:0] MAX_LVL = 5'(MAX_LEVEL);

   logic [31:0]          zin_x;
   logic [31:0]          zin_y;
   logic [13:0]          dw;
   logic [13:0]          dh;
   logic [13:0]          sw;
   logic [13:0]          sh;
   logic [31:0]          rs_x;
   logic [31:0]          rs_y;
   logic [CW-1:0]        world;
   logic [CW-1:0]        wmask;
   logic signed [CW-1:0] max_y;
   logic signed [CW-1:0] y_ext;
   logic [31:0]          clamp_y;

   always_comb begin
      zin_x = (req.kind == KIND_ZOOM_IN) ? {20'd0, view.width[12:1]}  : req.arg_x;
      zin_y = (req.kind == KIND_ZOOM_IN) ? {20'd0, view.height[12:1]} : req.arg_y;

      dw   = {1'b0, view.width}  - {1'b0, req.new_width};
      dh   = {1'b0, view.height} - {1'b0, req.new_height};
      sw   = dw + {13'd0, dw[13]};
      sh   = dh + {13'd0, dh[13]};
      rs_x = view.left + {{19{sw[13]}}, sw[13:1]};
      rs_y = view.top  + {{19{sh[13]}}, sh[13:1]};

      world = {{(CW-1){1'b0}}, 1'b1} << (6'(TILE_SHIFT) + {1'b0, view.level});
      wmask = world - {{(CW-1){1'b0}}, 1'b1};
      max_y = $signed(world) - $signed({{(CW-13){1'b0}}, view.height});
      y_ext = $signed({{(CW-32){view.top[31]}}, view.top});
      if (view.top[31]) begin
         clamp_y = 32'd0;
      end else if (y_ext > max_y) begin
         clamp_y = max_y[31:0];
      end else begin
         clamp_y = view.top;
      end

      view_next = view;
      unique case (req.kind)
         KIND_PAN: begin
            view_next.left = view.left + req.arg_x;
            view_next.top  = view.top + req.arg_y;
         end
         KIND_ZOOM_AT, KIND_ZOOM_IN: begin
            if (view.level < MAX_LVL) begin
               view_next.level = view.level + 5'd1;
               view_next.left  = {view.left[30:0], 1'b0} + zin_x;
               view_next.top   = {view.top[30:0], 1'b0} + zin_y;
            end
         end
         KIND_ZOOM_FROM: begin
            if (view.level > ZOOM_FROM_FLOOR) begin
               view_next.level = view.level - 5'd1;
               view_next.left  = half_back(view.left, view.width) - req.arg_x;
               view_next.top   = half_back(view.top, view.height) - req.arg_y;
            end
         end
         KIND_ZOOM_OUT: begin
            if (view.level > ZOOM_OUT_FLOOR) begin
               view_next.level = view.level - 5'd1;
               view_next.left  = half_back(view.left, view.width);
               view_next.top   = half_back(view.top, view.height);
            end
         end
         KIND_RESIZE: begin
            view_next.left   = rs_x;
            view_next.top    = rs_y;
            view_next.width  = req.new_width;
            view_next.height = req.new_height;
         end
         KIND_CLAMP_WRAP: begin
            view_next.left = view.left & wmask[31:0];
            view_next.top  = clamp_y;
         end
         KIND_INIT: begin
            view_next.left   = 32'd0;
            view_next.top    = 32'd0;
            view_next.width  = req.new_width;
            view_next.height = req.new_height;
            view_next.level  = (req.new_zoom > MAX_LVL) ? MAX_LVL : req.new_zoom;
         end
         default: begin
            view_next = view;
         end
      endcase
   end

endmodule
`default_nettype wire
